[src/rdwe_pkg.sv]
// Shared types and constants for the Rice decoder with escape.
// No dependencies; imported by every module of the block.
package rdwe_pkg;

	localparam int unsigned RDWE_QUEUE_DEPTH = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_RICE_PARAM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_WIDTH = 2'd2;

	localparam logic [5:0] ESC_WIDTH_MAX = 6'd32;

	typedef struct packed {
		logic [4:0] rice_param;
		logic [7:0] prefix_limit;
		logic [5:0] escape_width;
	} rdwe_cfg_t;

	localparam rdwe_cfg_t CFG_RESET = '{rice_param: 5'd0, prefix_limit: 8'd9,
		escape_width: 6'd16};

endpackage

[src/rdwe_byte_queue.sv]
// Front end: short byte queue between the input channel and the bit decoder.
// Depends on rdwe_pkg.
module rdwe_byte_queue import rdwe_pkg::*; #(
	parameter int unsigned DEPTH = RDWE_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       q_valid,
	output logic [7:0] q_byte,
	input  logic       q_pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [7:0]       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_stall = (count_q == CNT_FULL);
	assign q_valid  = (count_q != '0);
	assign q_byte   = mem_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[src/rdwe_bit_decoder.sv]
// Back end: walks one stream bit per cycle unless stalled, holds one pending
// result to mark each byte's last, drives the output register. Uses rdwe_pkg.
module rdwe_bit_decoder import rdwe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rdwe_cfg_t   cfg,
	input  logic        cfg_clr,
	input  logic        q_valid,
	input  logic [7:0]  q_byte,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic        is_error,
	output logic        last_of_byte
);

	typedef enum logic [1:0] {
		PH_PREFIX = 2'd0,
		PH_REM    = 2'd1,
		PH_ESC    = 2'd2,
		PH_HOLD   = 2'd3
	} phase_t;

	phase_t      phase_q, nx_phase;
	logic [7:0]  zc_q, nx_zc, zc_inc;
	logic [31:0] acc_q, nx_acc, acc_n;
	logic [5:0]  bl_q, nx_bl, bl_n;
	logic [7:0]  cur_q;
	logic [2:0]  idx_q;
	logic        busy_q;
	logic        pend_v_q, pend_done_q, pend_err_q;
	logic [31:0] pend_val_q;
	logic        out_valid_q, out_err_q, out_last_q;
	logic [31:0] out_val_q;

	logic [7:0]  lim;
	logic [5:0]  ew;
	logic        bit_in, prod, perr, bend;
	logic [31:0] pval;
	logic        slot_free, step, push, take;

	assign lim = (cfg.prefix_limit == 8'd0) ? 8'd1 : cfg.prefix_limit;
	assign ew  = (cfg.escape_width > ESC_WIDTH_MAX) ? ESC_WIDTH_MAX : cfg.escape_width;

	always_comb begin
		bit_in   = cur_q[idx_q];
		nx_phase = phase_q;
		nx_zc    = zc_q;
		nx_acc   = acc_q;
		nx_bl    = bl_q;
		prod     = 1'b0;
		perr     = 1'b0;
		pval     = '0;
		bend     = (idx_q == 3'd0);
		zc_inc   = zc_q + 8'd1;
		acc_n    = {acc_q[30:0], bit_in};
		bl_n     = bl_q - 6'd1;
		case (phase_q)
			PH_PREFIX: begin
				if (!bit_in) begin
					if (zc_inc >= lim) begin
						prod     = 1'b1;
						perr     = 1'b1;
						nx_phase = PH_HOLD;
						nx_zc    = '0;
						nx_acc   = '0;
						nx_bl    = '0;
						bend     = 1'b1;
					end else begin
						nx_zc = zc_inc;
					end
				end else if ({1'b0, zc_q} + 9'd1 == {1'b0, lim}) begin
					nx_zc  = '0;
					nx_acc = '0;
					if (ew == 6'd0) begin
						prod = 1'b1;
						pval = 32'd1;
					end else begin
						nx_bl    = ew;
						nx_phase = PH_ESC;
					end
				end else if (cfg.rice_param == 5'd0) begin
					prod  = 1'b1;
					pval  = {24'd0, zc_q};
					nx_zc = '0;
				end else begin
					nx_acc   = '0;
					nx_bl    = {1'b0, cfg.rice_param};
					nx_phase = PH_REM;
				end
			end
			PH_REM, PH_ESC: begin
				nx_acc = acc_n;
				nx_bl  = bl_n;
				if (bl_n == 6'd0) begin
					prod     = 1'b1;
					pval     = (phase_q == PH_REM)
						? ({24'd0, zc_q} << cfg.rice_param) + acc_n
						: acc_n + 32'd1;
					nx_phase = PH_PREFIX;
					nx_zc    = '0;
					nx_acc   = '0;
				end
			end
			default: begin
				bend = 1'b1;
			end
		endcase
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign step      = busy_q && (!(prod && pend_v_q) || slot_free);
	assign push      = slot_free && pend_v_q && (pend_done_q || (busy_q && prod));
	assign take      = q_valid && (!busy_q || (step && bend));
	assign q_pop     = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PREFIX;
			zc_q        <= '0;
			acc_q       <= '0;
			bl_q        <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			busy_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_done_q <= 1'b0;
			pend_val_q  <= '0;
			pend_err_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_val_q   <= '0;
			out_err_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_clr) begin
				phase_q <= PH_PREFIX;
				zc_q    <= '0;
				acc_q   <= '0;
				bl_q    <= '0;
			end else if (step) begin
				phase_q <= nx_phase;
				zc_q    <= nx_zc;
				acc_q   <= nx_acc;
				bl_q    <= nx_bl;
			end
			if (take) begin
				cur_q  <= q_byte;
				busy_q <= 1'b1;
				idx_q  <= 3'd7;
			end else if (step) begin
				if (bend) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 3'd1;
				end
			end
			if (step && prod) begin
				pend_v_q    <= 1'b1;
				pend_done_q <= bend;
				pend_val_q  <= pval;
				pend_err_q  <= perr;
			end else if (push) begin
				pend_v_q    <= 1'b0;
				pend_done_q <= 1'b0;
			end else if (step && bend) begin
				pend_done_q <= pend_v_q;
			end
			if (push) begin
				out_valid_q <= 1'b1;
				out_val_q   <= pend_val_q;
				out_err_q   <= pend_err_q;
				out_last_q  <= pend_done_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = out_val_q;
	assign is_error     = out_err_q;
	assign last_of_byte = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n) pend_done_q |-> pend_v_q)
		else $error("pending end-of-byte mark without a pending result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HOLD) |-> (zc_q == 8'd0 && bl_q == 6'd0))
		else $error("error hold with live decode state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_REM || phase_q == PH_ESC) |-> (bl_q != 6'd0))
		else $error("field phase with no bits left");
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && prod && pend_v_q) |-> push)
		else $error("pending result overwritten without being sent");

endmodule

[src/rice_decode_with_escape_top.sv]
// Top level of the Rice decoder with escape: configuration registers, front
// byte queue and back bit decoder. Depends on rdwe_pkg and both submodules.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   data_byte
//  out      source     out_valid / out_stall value, is_error, last_of_byte
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One stream bit is decoded per cycle while the decoder is not halted. The walk
// of a byte stops at its error bit, and a byte in error hold is dropped.
// A result waits in a pending register; once the output register is free it
// enters it as the next code closes, or after its end-of-byte mark is set.
// Reset and any write to cfg_index 0 to 2 return the decoder to prefix counting.
// A stalled output halts the decoder only when a result is already pending
// behind the stalled beat and another code closes.
module rice_decode_with_escape_top import rdwe_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = RDWE_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           value,
	output logic                  is_error,
	output logic                  last_of_byte,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	rdwe_cfg_t  cfg_q;
	logic       cfg_wr;
	logic       cfg_clr;
	logic       q_valid;
	logic [7:0] q_byte;
	logic       q_pop;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_clr   = cfg_wr
		&& (cfg_index inside {CFG_RICE_PARAM, CFG_PREFIX_LIMIT, CFG_ESCAPE_WIDTH});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_RICE_PARAM:   cfg_q.rice_param   <= cfg_data[4:0];
				CFG_PREFIX_LIMIT: cfg_q.prefix_limit <= cfg_data[7:0];
				CFG_ESCAPE_WIDTH: cfg_q.escape_width <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	rdwe_byte_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.q_valid   (q_valid),
		.q_byte    (q_byte),
		.q_pop     (q_pop)
	);

	rdwe_bit_decoder u_decoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cfg_clr      (cfg_clr),
		.q_valid      (q_valid),
		.q_byte       (q_byte),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.is_error     (is_error),
		.last_of_byte (last_of_byte)
	);

endmodule

[tb/tb_rice_decode_with_escape_top.sv]
// Self-checking bench for rice_decode_with_escape_top: drives coded bytes, predicts
// every decoded value in a bit-serial model and checks each output beat in order.
// Depends on rdwe_pkg and the RTL of the block only.
module tb_rice_decode_with_escape_top import rdwe_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
	localparam int DRAIN_CYCLES = 64;

	typedef enum logic [1:0] {DEC_PREFIX, DEC_REMAINDER, DEC_ESCAPE, DEC_HOLD} dec_phase_t;

	typedef struct packed {
		logic [31:0] value;
		logic        is_error;
		logic        closes_byte;
	} decoded_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            data_byte = 8'd0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [31:0]           value;
	logic                  is_error;
	logic                  last_of_byte;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// decoder copy
	logic [4:0]  rice_k = CFG_RESET.rice_param;
	logic [7:0]  zero_limit = CFG_RESET.prefix_limit;
	logic [5:0]  raw_width = CFG_RESET.escape_width;
	dec_phase_t  dec_phase = DEC_PREFIX;
	logic [7:0]  dec_zeros = 8'd0;
	logic [31:0] dec_accum = 32'd0;
	logic [5:0]  dec_left = 6'd0;

	decoded_t codes_due[$];
	logic     stream_bits[$];
	int       fails = 0;
	bit       src_idle_en = 1'b1;
	bit       sink_idle_en = 1'b1;
	int       sink_hold_left = 0;

	rice_decode_with_escape_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .value(value),
		.is_error(is_error), .last_of_byte(last_of_byte),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic decoded_t code_of(input logic [31:0] v, input logic err);
		decoded_t r;
		r.value = v;
		r.is_error = err;
		r.closes_byte = 1'b0;
		return r;
	endfunction

	task automatic clear_decoder();
		dec_phase = DEC_PREFIX;
		dec_zeros = 8'd0;
		dec_accum = 32'd0;
		dec_left = 6'd0;
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [7:0]  lim;
		logic [5:0]  ew;
		logic [31:0] v;
		decoded_t    found[$];
		decoded_t    r;
		lim = (zero_limit == 8'd0) ? 8'd1 : zero_limit;
		ew = (raw_width > ESC_WIDTH_MAX) ? ESC_WIDTH_MAX : raw_width;
		for (int i = 7; i >= 0; i--) begin
			if (dec_phase == DEC_HOLD) break;
			if (dec_phase == DEC_PREFIX) begin
				if (!b[i]) begin
					dec_zeros = dec_zeros + 8'd1;
					if (dec_zeros >= lim) begin
						found.push_back(code_of(32'd0, 1'b1));
						clear_decoder();
						dec_phase = DEC_HOLD;
					end
				end else if ({1'b0, dec_zeros} + 9'd1 == {1'b0, lim}) begin
					dec_zeros = 8'd0;
					dec_accum = 32'd0;
					if (ew == 6'd0) begin
						found.push_back(code_of(32'd1, 1'b0));
					end else begin
						dec_left = ew;
						dec_phase = DEC_ESCAPE;
					end
				end else if (rice_k == 5'd0) begin
					found.push_back(code_of(32'(dec_zeros), 1'b0));
					dec_zeros = 8'd0;
				end else begin
					dec_accum = 32'd0;
					dec_left = 6'(rice_k);
					dec_phase = DEC_REMAINDER;
				end
			end else begin
				dec_accum = {dec_accum[30:0], b[i]};
				dec_left = dec_left - 6'd1;
				if (dec_left == 6'd0) begin
					if (dec_phase == DEC_REMAINDER)
						v = (32'(dec_zeros) << rice_k) + dec_accum;
					else
						v = dec_accum + 32'd1;
					found.push_back(code_of(v, 1'b0));
					dec_phase = DEC_PREFIX;
					dec_zeros = 8'd0;
					dec_accum = 32'd0;
				end
			end
		end
		foreach (found[j]) begin
			r = found[j];
			r.closes_byte = (j == found.size() - 1);
			codes_due.push_back(r);
		end
	endtask

	// sink: check beats, stall in bursts or on request
	initial begin : sink
		decoded_t want;
		logic     stall_next;
		int       burst_left;
		burst_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (codes_due.size() == 0) begin
					$error("unexpected beat: value %h is_error %b last_of_byte %b",
						value, is_error, last_of_byte);
					fails++;
				end else begin
					want = codes_due.pop_front();
					if (value !== want.value) begin
						$error("value: expected %h, actual %h", want.value, value);
						fails++;
					end
					if (is_error !== want.is_error) begin
						$error("is_error: expected %b, actual %b", want.is_error, is_error);
						fails++;
					end
					if (last_of_byte !== want.closes_byte) begin
						$error("last_of_byte: expected %b, actual %b",
							want.closes_byte, last_of_byte);
						fails++;
					end
				end
			end
			if (sink_hold_left > 0) begin
				sink_hold_left--;
				stall_next = 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				stall_next = 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 16) - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			out_stall <= stall_next;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		decode_byte(b);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (codes_due.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RICE_PARAM: rice_k = d[4:0];
			CFG_PREFIX_LIMIT: zero_limit = d;
			CFG_ESCAPE_WIDTH: raw_width = d[5:0];
			default: ;
		endcase
		if (idx != CFG_SPARE_IDX) clear_decoder();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [7:0] k, input logic [7:0] lim, input logic [7:0] ew);
		settle();
		write_reg(CFG_RICE_PARAM, k);
		write_reg(CFG_PREFIX_LIMIT, lim);
		write_reg(CFG_ESCAPE_WIDTH, ew);
	endtask

	task automatic random_config();
		logic [7:0] k;
		logic [7:0] lim;
		logic [7:0] ew;
		k = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
		lim = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(2, 12));
		ew = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 32));
		write_all(k, lim, ew);
	endtask

	task automatic push_bits(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
	endtask

	task automatic push_zeros(input int n);
		repeat (n) stream_bits.push_back(1'b0);
	endtask

	// pad to a byte boundary with noise, then send
	task automatic flush_stream();
		logic [7:0] b;
		while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
		while (stream_bits.size() != 0) begin
			for (int i = 7; i >= 0; i--) b[i] = stream_bits.pop_front();
			send_byte(b);
		end
	endtask

	task automatic send_codes(input int nbytes, input bit with_error);
		int lim;
		int ew;
		int q;
		int sel;
		lim = (zero_limit == 8'd0) ? 1 : int'(zero_limit);
		ew = (raw_width > ESC_WIDTH_MAX) ? 32 : int'(raw_width);
		while (stream_bits.size() < nbytes * 8) begin
			sel = $urandom_range(0, 15);
			if (with_error && sel == 0 && stream_bits.size() >= nbytes * 4) begin
				push_zeros(lim);
				break;
			end
			if (lim < 2 || sel < 4) begin
				push_zeros(lim - 1);
				stream_bits.push_back(1'b1);
				push_bits($urandom, ew);
			end else begin
				q = (sel == 15) ? lim - 2 : $urandom_range(0, (lim - 2 < 6) ? lim - 2 : 6);
				push_zeros(q);
				stream_bits.push_back(1'b1);
				push_bits($urandom, int'(rice_k));
			end
		end
		flush_stream();
	endtask

	task automatic test_reset_defaults();
		logic [7:0] seq[$];
		seq = '{8'hFF, 8'h55, 8'hAA, 8'h01, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF};
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	task automatic test_register_extremes();
		// longest remainder, widest limit, escape width saturating
		write_all(8'hFF, 8'hFF, 8'hFF);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h7F);
		// zero limit acts as one, zero escape width yields one
		write_all(8'h00, 8'h00, 8'h40);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'hC3);
		// full 32-bit escape field
		write_all(8'h00, 8'h01, 8'h20);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		settle();
		write_reg(CFG_SPARE_IDX, 8'hA5);
		write_all(8'h00, 8'h02, 8'h01);
		send_byte(8'h5A);
		send_byte(8'h2D);
	endtask

	task automatic test_random_streams();
		for (int p = 0; p < 5; p++) begin
			random_config();
			send_codes(22, p % 2 == 1);
		end
		settle();
		write_reg(CFG_PREFIX_LIMIT, 8'($urandom_range(1, 255)));
		repeat (12) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic test_output_backpressure();
		write_all(8'h00, 8'h09, 8'h10);
		sink_hold_left = 240;
		repeat (24) send_byte(8'h81 | 8'($urandom_range(0, 255)));
	endtask

	task automatic test_sender_pause();
		random_config();
		send_codes(10, 1'b0);
		wait_drained();
		send_codes(10, 1'b0);
	endtask

	task automatic test_full_rate();
		settle();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		random_config();
		send_codes(24, 1'b0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_streams();
		test_output_backpressure();
		test_sender_pause();
		test_full_rate();
		settle();
		if (fails == 0)
			$display("PASS rice_decode_with_escape_top");
		else
			$display("FAIL rice_decode_with_escape_top");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("FAIL rice_decode_with_escape_top");
		$finish;
	end

endmodule
